// ===== rtl/core/bcs_pkg.sv =====
package bcs_pkg;

  localparam int MAX_POINTS = 256;
  localparam int MAX_ORDER  = 8;
  localparam int FRAC_BITS  = 16;
  localparam int SCALE_DEN  = 100000;

  localparam int ORDER_W   = 4;
  localparam int DIMS_W    = 2;
  localparam int PCNT_W    = 9;
  localparam int SCNT_W    = 16;
  localparam int CFG_W     = 16;
  localparam int CIDX_W    = 2;
  localparam int PIDX_IN_W = 8;
  localparam int IDX_W     = 16;
  localparam int CRD_W     = 32;

  localparam int N_W     = $clog2(MAX_POINTS + 1);
  localparam int K_W     = $clog2(MAX_ORDER + 1);
  localparam int T_W     = $clog2(MAX_ORDER);
  localparam int PADR_W  = $clog2(MAX_POINTS);
  localparam int KI_W    = $clog2(MAX_POINTS + 2 * MAX_ORDER + 1);
  localparam int BW      = FRAC_BITS + 1;
  localparam int DIFF_W  = FRAC_BITS + $clog2(MAX_ORDER);
  localparam int SHORT_W = DIFF_W + 1;
  localparam int NUM_W   = N_W + IDX_W;
  localparam int UQ_W    = NUM_W + FRAC_BITS;
  localparam int DVD_W   = UQ_W + 1;
  localparam int DVS_W   = $clog2(SCALE_DEN + 1);
  localparam int DCNT_W  = $clog2(DVD_W + 1);
  localparam int MA_W    = CRD_W + 1;
  localparam int MB_W    = ((BW > IDX_W) ? BW : IDX_W) + 1;
  localparam int P_W     = MA_W + MB_W;
  localparam int ACC_W   = P_W + $clog2(MAX_ORDER + 1);
  localparam int RAM_W   = 3 * CRD_W;

  localparam int     RCP_FRAC  = 32;
  localparam int     RZ_W      = 32;
  localparam int     RCP_SHIFT = DVD_W - RZ_W;
  localparam longint RCP_M     = (longint'(1) << (RCP_FRAC + RCP_SHIFT)) / SCALE_DEN;
  localparam int     RCP_W     = $clog2(RCP_M + 1);
  localparam int     RQ_W      = RZ_W + RCP_W - RCP_FRAC;
  localparam int     RR_W      = DVS_W + 2;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  typedef enum logic [CIDX_W-1:0] {
    CFG_ORDER = 2'd0,
    CFG_DIMS  = 2'd1,
    CFG_PCNT  = 2'd2,
    CFG_SCNT  = 2'd3
  } cfg_idx_e;

  typedef enum logic [4:0] {
    S_IDLE, S_UMUL, S_UDIV, S_UWAIT, S_CMUL, S_CREM, S_CFIX1, S_CFIX2, S_CSUB, S_CHECK,
    S_T1, S_T1D, S_T1W, S_T2, S_T2D, S_T2W, S_SHIFT,
    S_BRD, S_BX, S_BY, S_BZ, S_BACC, S_DONE
  } core_state_e;

  typedef struct packed {
    logic                    req_type;
    logic [PIDX_IN_W-1:0]    point_index;
    logic signed [CRD_W-1:0] coord_x;
    logic signed [CRD_W-1:0] coord_y;
    logic signed [CRD_W-1:0] coord_z;
    logic [IDX_W-1:0]        sample_index;
  } in_item_t;

  typedef struct packed {
    logic signed [CRD_W-1:0] out_x;
    logic signed [CRD_W-1:0] out_y;
    logic signed [CRD_W-1:0] out_z;
  } out_item_t;

  typedef struct packed {
    logic [N_W-1:0]    n;
    logic [K_W-1:0]    k;
    logic [DIMS_W-1:0] dims;
    logic [SCNT_W-1:0] s1;
  } cfg_t;

  function automatic logic [N_W-1:0] knot_at(input logic [KI_W-1:0] i,
                                             input logic [K_W-1:0] k,
                                             input logic [N_W-1:0] n);
    int ii;
    int kk;
    int nn;
    ii = int'(i);
    kk = int'(k);
    nn = int'(n);
    if (ii < kk) begin
      return '0;
    end else if (ii > nn - 1) begin
      return N_W'(nn - kk + 1);
    end
    return N_W'(ii - kk + 1);
  endfunction

  function automatic logic signed [CRD_W-1:0] sat_crd(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] s;
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    s  = v >>> FRAC_BITS;
    hi = {{(ACC_W-CRD_W+1){1'b0}}, {(CRD_W-1){1'b1}}};
    lo = {{(ACC_W-CRD_W+1){1'b1}}, {(CRD_W-1){1'b0}}};
    if (s > hi) begin
      return hi[CRD_W-1:0];
    end else if (s < lo) begin
      return lo[CRD_W-1:0];
    end
    return s[CRD_W-1:0];
  endfunction

endpackage

// ===== rtl/core/bcs_ram.sv =====
module bcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/bcs_div.sv =====
module bcs_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        short_i,
  input  logic [bcs_pkg::DVD_W-1:0]   dividend_i,
  input  logic [bcs_pkg::DVS_W-1:0]   divisor_i,
  output logic                        done_o,
  output logic [bcs_pkg::DVD_W-1:0]   quot_o
);
  import bcs_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [DVS_W-1:0]  rem_q;
  logic [DVS_W-1:0]  dvs_q;
  logic [DVD_W-1:0]  quo_q;
  logic [DVS_W:0]    shifted;
  logic              ge;
  logic [DVS_W:0]    sub;

  assign shifted = {rem_q, quo_q[DVD_W-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign sub     = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= short_i ? DCNT_W'(SHORT_W) : DCNT_W'(DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DCNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      quo_q <= short_i ? {dividend_i[SHORT_W-1:0], {(DVD_W-SHORT_W){1'b0}}} : dividend_i;
    end else if (busy_q) begin
      rem_q <= ge ? sub[DVS_W-1:0] : shifted[DVS_W-1:0];
      quo_q <= {quo_q[DVD_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== rtl/core/bcs_core.sv =====
module bcs_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bcs_pkg::cfg_t      cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bcs_pkg::in_item_t  in_data_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output bcs_pkg::out_item_t res_o
);
  import bcs_pkg::*;

  core_state_e state_q, state_d;

  logic [IDX_W-1:0]         idx_q;
  logic [UQ_W-1:0]          uq_q;
  logic [DVD_W-1:0]         cx_q;
  logic [RQ_W-1:0]          qe_q;
  logic [RR_W-1:0]          rr_q;
  logic [PADR_W-1:0]        base_q;
  logic [K_W-1:0]           j_q;
  logic [T_W-1:0]           t_q;
  logic [BW-1:0]            b_q [MAX_ORDER];
  logic [BW:0]              sum_q;
  logic [N_W-1:0]           span_q;
  logic signed [P_W-1:0]    prod_q;
  logic signed [ACC_W-1:0]  acc_x_q, acc_y_q, acc_z_q;

  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [P_W-1:0]    prod_d;

  logic [RZ_W+RCP_W-1:0]    rcp_prod;
  logic [DVD_W-1:0]         qe_scaled;

  logic                     div_start, div_short, div_done;
  logic [DVD_W-1:0]         div_dividend, div_quot;
  logic [DVS_W-1:0]         div_divisor;

  logic                     ram_we, ram_re;
  logic [PADR_W-1:0]        ram_waddr, ram_raddr;
  logic [RAM_W-1:0]         ram_wdata, ram_rdata;

  logic [K_W-1:0]           km1;
  logic                     last_t;
  logic [NUM_W-1:0]         ui_full;
  logic                     fits;
  logic [KI_W-1:0]          i_idx;
  logic [N_W-1:0]           ka, kb, kc, kd, span1, span2;
  logic [UQ_W-1:0]          diff1_w, diff2_w;
  logic [BW-1:0]            nb;
  logic                     term1_ok, term2_ok, slot_ok, take_in;

  assign km1       = cfg_i.k - 1'b1;
  assign last_t    = (K_W'(t_q) == km1);
  assign ui_full   = uq_q[UQ_W-1:FRAC_BITS];
  assign fits      = ui_full <= NUM_W'(cfg_i.n - N_W'(cfg_i.k));
  assign i_idx     = KI_W'(base_q) + KI_W'(t_q);
  assign ka        = knot_at(i_idx, cfg_i.k, cfg_i.n);
  assign kb        = knot_at(i_idx + KI_W'(j_q) - 1'b1, cfg_i.k, cfg_i.n);
  assign kc        = knot_at(i_idx + KI_W'(j_q), cfg_i.k, cfg_i.n);
  assign kd        = knot_at(i_idx + 1'b1, cfg_i.k, cfg_i.n);
  assign span1     = kb - ka;
  assign span2     = kc - kd;
  assign diff1_w   = uq_q - (UQ_W'(ka) << FRAC_BITS);
  assign diff2_w   = (UQ_W'(kc) << FRAC_BITS) - uq_q;
  assign nb        = last_t ? '0 : b_q[1];
  assign term1_ok  = (span1 != '0) && (b_q[0] != '0);
  assign term2_ok  = (span2 != '0) && (nb != '0);
  assign slot_ok   = 32'(in_data_i.point_index) < MAX_POINTS;
  assign take_in   = in_valid_i && (state_q == S_IDLE);
  assign prod_d    = mul_a * mul_b;
  assign rcp_prod  = cx_q[DVD_W-1:RCP_SHIFT] * RCP_W'(RCP_M);
  assign qe_scaled = DVD_W'(qe_q) * DVD_W'(SCALE_DEN);

  bcs_ram #(.WIDTH(RAM_W), .DEPTH(MAX_POINTS)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  bcs_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .short_i   (div_short),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (take_in && in_data_i.req_type == REQ_SAMPLE) state_d = S_UMUL;
      end
      S_UMUL:  state_d = S_UDIV;
      S_UDIV:  state_d = (cfg_i.s1 == '0) ? S_CHECK : S_UWAIT;
      S_UWAIT: if (div_done) state_d = S_CMUL;
      S_CMUL:  state_d = S_CREM;
      S_CREM:  state_d = S_CFIX1;
      S_CFIX1: state_d = S_CFIX2;
      S_CFIX2: state_d = S_CSUB;
      S_CSUB:  state_d = S_CHECK;
      S_CHECK: begin
        if (!fits) state_d = S_DONE;
        else if (cfg_i.k == K_W'(1)) state_d = S_BRD;
        else state_d = S_T1;
      end
      S_T1:    state_d = term1_ok ? S_T1D : S_T2;
      S_T1D:   state_d = S_T1W;
      S_T1W:   if (div_done) state_d = S_T2;
      S_T2:    state_d = term2_ok ? S_T2D : S_SHIFT;
      S_T2D:   state_d = S_T2W;
      S_T2W:   if (div_done) state_d = S_SHIFT;
      S_SHIFT: state_d = (last_t && j_q == cfg_i.k) ? S_BRD : S_T1;
      S_BRD:   state_d = S_BX;
      S_BX:    state_d = S_BY;
      S_BY:    state_d = S_BZ;
      S_BZ:    state_d = S_BACC;
      S_BACC:  state_d = last_t ? S_DONE : S_BRD;
      S_DONE:  if (res_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    res_valid_o  = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = PADR_W'(in_data_i.point_index);
    ram_wdata    = {in_data_i.coord_z, in_data_i.coord_y, in_data_i.coord_x};
    ram_raddr    = PADR_W'(i_idx);
    div_start    = 1'b0;
    div_short    = 1'b0;
    div_dividend = '0;
    div_divisor  = DVS_W'(span_q);
    mul_a        = '0;
    mul_b        = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        ram_we     = take_in && in_data_i.req_type == REQ_LOAD && slot_ok;
      end
      S_UMUL: begin
        mul_a = MA_W'(cfg_i.n + 1'b1 - N_W'(cfg_i.k));
        mul_b = MB_W'(idx_q);
      end
      S_UDIV: begin
        div_start    = cfg_i.s1 != '0;
        div_dividend = DVD_W'({prod_q[NUM_W-1:0], {FRAC_BITS{1'b0}}});
        div_divisor  = DVS_W'(cfg_i.s1);
      end
      S_T1: begin
        mul_a = MA_W'(diff1_w[DIFF_W-1:0]);
        mul_b = MB_W'(b_q[0]);
      end
      S_T2: begin
        mul_a = MA_W'(diff2_w[DIFF_W-1:0]);
        mul_b = MB_W'(nb);
      end
      S_T1D, S_T2D: begin
        div_start    = 1'b1;
        div_short    = 1'b1;
        div_dividend = DVD_W'(prod_q[FRAC_BITS+SHORT_W-1:FRAC_BITS]);
      end
      S_BRD: ram_re = 1'b1;
      S_BX: begin
        mul_a = MA_W'(signed'(ram_rdata[CRD_W-1:0]));
        mul_b = MB_W'(b_q[0]);
      end
      S_BY: begin
        mul_a = MA_W'(signed'(ram_rdata[2*CRD_W-1:CRD_W]));
        mul_b = MB_W'(b_q[0]);
      end
      S_BZ: begin
        mul_a = MA_W'(signed'(ram_rdata[3*CRD_W-1:2*CRD_W]));
        mul_b = MB_W'(b_q[0]);
      end
      S_DONE: res_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    case (state_q)
      S_IDLE: idx_q <= in_data_i.sample_index;
      S_UDIV: if (cfg_i.s1 == '0) uq_q <= '0;
      S_UWAIT: begin
        if (div_done) begin
          uq_q <= div_quot[UQ_W-1:0];
          cx_q <= div_quot + DVD_W'(SCALE_DEN - 1);
        end
      end
      S_CMUL: qe_q <= rcp_prod[RZ_W+RCP_W-1:RCP_FRAC];
      S_CREM: rr_q <= RR_W'(cx_q - qe_scaled);
      S_CFIX1, S_CFIX2: begin
        if (rr_q >= RR_W'(SCALE_DEN)) begin
          rr_q <= rr_q - RR_W'(SCALE_DEN);
          qe_q <= qe_q + 1'b1;
        end
      end
      S_CSUB: uq_q <= uq_q - UQ_W'(qe_q);
      S_CHECK: begin
        base_q  <= ui_full[PADR_W-1:0];
        j_q     <= K_W'(2);
        t_q     <= '0;
        acc_x_q <= '0;
        acc_y_q <= '0;
        acc_z_q <= '0;
        for (int e = 0; e < MAX_ORDER; e++) begin
          b_q[e] <= (K_W'(e) == km1) ? BW'(1 << FRAC_BITS) : '0;
        end
      end
      S_T1: begin
        sum_q  <= '0;
        span_q <= span1;
      end
      S_T1W: if (div_done) sum_q <= (BW+1)'(div_quot[BW-1:0]);
      S_T2: span_q <= span2;
      S_T2W: if (div_done) sum_q <= sum_q + (BW+1)'(div_quot[BW-1:0]);
      S_SHIFT: begin
        for (int e = 0; e < MAX_ORDER - 1; e++) begin
          b_q[e] <= (K_W'(e) == km1) ? sum_q[BW-1:0] : b_q[e+1];
        end
        if (K_W'(MAX_ORDER - 1) == km1) b_q[MAX_ORDER-1] <= sum_q[BW-1:0];
        if (last_t) begin
          t_q <= '0;
          j_q <= j_q + 1'b1;
        end else begin
          t_q <= t_q + 1'b1;
        end
      end
      S_BY: acc_x_q <= acc_x_q + ACC_W'(prod_q);
      S_BZ: acc_y_q <= acc_y_q + ACC_W'(prod_q);
      S_BACC: begin
        acc_z_q <= acc_z_q + ACC_W'(prod_q);
        for (int e = 0; e < MAX_ORDER - 1; e++) begin
          b_q[e] <= b_q[e+1];
        end
        t_q <= t_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    res_o.out_x = sat_crd(acc_x_q);
    res_o.out_y = (cfg_i.dims >= DIMS_W'(2)) ? sat_crd(acc_y_q) : '0;
    res_o.out_z = (cfg_i.dims >= DIMS_W'(3)) ? sat_crd(acc_z_q) : '0;
  end

endmodule

// ===== rtl/core/bspline_curve_sampler_top.sv =====
// Channel   Direction  Handshake                    Payload
// in        input      in_valid_i / in_ready_o      in_data_i  (load or sample request)
// out       output     out_valid_o / out_ready_i    out_data_o (curve point)
// cfg       input      cfg_valid_i / cfg_ready_o    cfg_index_i, cfg_data_i
//
// A load is written to the point memory from idle. A sample first computes the curve
// parameter with the bit-serial divider (not used when the sample count is 0 or 1),
// then the basis weights, then blends the points and hands off the result.
// Reset clears control and configuration only; the point memory has no clearing pass.
// A finished result waits in the output register while the next request is taken.
module bspline_curve_sampler_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  bcs_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output bcs_pkg::out_item_t            out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bcs_pkg::CIDX_W-1:0]    cfg_index_i,
  input  logic [bcs_pkg::CFG_W-1:0]     cfg_data_i
);
  import bcs_pkg::*;

  logic [ORDER_W-1:0] order_q;
  logic [DIMS_W-1:0]  dims_q;
  logic [PCNT_W-1:0]  pcnt_q;
  logic [SCNT_W-1:0]  scnt_q;
  cfg_t               cfg;
  logic               res_valid, res_ready;
  out_item_t          res;
  logic               out_valid_q;
  out_item_t          out_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= ORDER_W'(4);
      dims_q  <= DIMS_W'(3);
      pcnt_q  <= PCNT_W'(4);
      scnt_q  <= SCNT_W'(10);
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ORDER: order_q <= cfg_data_i[ORDER_W-1:0];
        CFG_DIMS:  dims_q  <= cfg_data_i[DIMS_W-1:0];
        CFG_PCNT:  pcnt_q  <= cfg_data_i[PCNT_W-1:0];
        CFG_SCNT:  scnt_q  <= cfg_data_i[SCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    int nn;
    int kk;
    nn = int'(pcnt_q);
    if (nn < 1) nn = 1;
    if (nn > MAX_POINTS) nn = MAX_POINTS;
    kk = int'(order_q);
    if (kk < 1) kk = 1;
    if (kk > MAX_ORDER) kk = MAX_ORDER;
    if (kk > nn) kk = nn;
    cfg.n    = N_W'(nn);
    cfg.k    = K_W'(kk);
    cfg.dims = (dims_q == '0) ? DIMS_W'(1) : dims_q;
    cfg.s1   = (scnt_q > SCNT_W'(1)) ? scnt_q - 1'b1 : '0;
  end

  bcs_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== verif/bspline_curve_sampler_top_tb.sv =====
module bspline_curve_sampler_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bcs_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES = 3000;

  logic clk_i;
  logic rst_ni;
  logic in_valid;
  logic in_ready_o;
  in_item_t in_data;
  logic out_valid_o;
  logic out_ready;
  out_item_t out_data_o;
  logic cfg_valid;
  logic cfg_ready_o;
  logic [CIDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  bspline_curve_sampler_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  in_item_t request_q[$];
  out_item_t curve_q[$];

  logic signed [CRD_W-1:0] pt_store[3][MAX_POINTS];
  longint unsigned basis_w[MAX_POINTS+MAX_ORDER];
  bit loaded[MAX_POINTS];

  int cfg_order;
  int cfg_dims;
  int cfg_points;
  int cfg_samples;

  int errors;
  int requests_sent;
  int points_seen;
  int settings_done;
  int in_gap;
  int out_stall;
  int hold_left;
  bit held_once;
  bit no_gaps;
  int idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint unsigned knot_pos(int i, int k, int n);
    if (i < k) return 0;
    if (i > n - 1) return longint'(n - k + 1);
    return longint'(i - k + 1);
  endfunction

  function automatic int eff_points();
    int n;
    n = cfg_points;
    if (n < 1) n = 1;
    if (n > MAX_POINTS) n = MAX_POINTS;
    return n;
  endfunction

  function automatic logic signed [CRD_W-1:0] blend_axis(int axis, int n);
    longint acc;
    longint res;
    acc = 0;
    for (int i = 0; i < n; i++) begin
      acc += longint'(pt_store[axis][i]) * longint'(basis_w[i]);
    end
    res = acc >>> FRAC_BITS;
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    return res[CRD_W-1:0];
  endfunction

  function automatic out_item_t curve_point(logic [IDX_W-1:0] sidx);
    int n;
    int k;
    int dims;
    int s1;
    longint unsigned uq;
    longint unsigned num;
    longint unsigned v;
    longint unsigned ki;
    longint unsigned kj;
    longint unsigned k1;
    longint unsigned span;
    out_item_t res;
    n = eff_points();
    k = cfg_order;
    if (k < 1) k = 1;
    if (k > MAX_ORDER) k = MAX_ORDER;
    if (k > n) k = n;
    dims = (cfg_dims < 1) ? 1 : cfg_dims;
    s1 = (cfg_samples > 1) ? cfg_samples - 1 : 0;
    if (s1 == 0) begin
      uq = 0;
    end else begin
      num = longint'(n + 1 - k) * longint'(sidx);
      uq = ((num / s1) << FRAC_BITS) + (((num % s1) << FRAC_BITS) / s1);
      uq = uq - (uq + SCALE_DEN - 1) / SCALE_DEN;
    end
    for (int i = 0; i <= n + k - 2; i++) begin
      basis_w[i] = ((knot_pos(i, k, n) << FRAC_BITS) <= uq &&
                    uq < (knot_pos(i + 1, k, n) << FRAC_BITS)) ? (64'd1 << FRAC_BITS) : 0;
    end
    for (int j = 2; j <= k; j++) begin
      for (int i = 0; i <= n + k - 1 - j; i++) begin
        v = 0;
        ki = knot_pos(i, k, n);
        span = knot_pos(i + j - 1, k, n) - ki;
        if (span != 0 && basis_w[i] != 0) begin
          v += ((uq - (ki << FRAC_BITS)) * basis_w[i]) / (span << FRAC_BITS);
        end
        kj = knot_pos(i + j, k, n);
        k1 = knot_pos(i + 1, k, n);
        span = kj - k1;
        if (span != 0 && basis_w[i+1] != 0) begin
          v += (((kj << FRAC_BITS) - uq) * basis_w[i+1]) / (span << FRAC_BITS);
        end
        basis_w[i] = v;
      end
    end
    res.out_x = blend_axis(0, n);
    res.out_y = (dims >= 2) ? blend_axis(1, n) : '0;
    res.out_z = (dims >= 3) ? blend_axis(2, n) : '0;
    return res;
  endfunction

  task automatic apply_request(in_item_t item);
    if (item.req_type == REQ_LOAD) begin
      pt_store[0][item.point_index] = item.coord_x;
      pt_store[1][item.point_index] = item.coord_y;
      pt_store[2][item.point_index] = item.coord_z;
    end else begin
      curve_q.push_back(curve_point(item.sample_index));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data <= '0;
      in_gap <= 0;
    end else begin
      if (in_valid && in_ready_o) begin
        apply_request(in_data);
      end
      if (!in_valid || in_ready_o) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (request_q.size() > 0) begin
          in_data <= request_q.pop_front();
          in_valid <= 1'b1;
          in_gap <= no_gaps ? 0 : $urandom_range(0, 9);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [CRD_W-1:0] exp_v, logic [CRD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_pt;
    int draw;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      out_stall <= 0;
      hold_left <= 0;
      held_once <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        points_seen++;
        if (curve_q.size() == 0) begin
          $display("%0t: unexpected curve point, expected none, actual %h", $time, out_data_o);
          errors++;
        end else begin
          exp_pt = curve_q.pop_front();
          check_field("out_x", exp_pt.out_x, out_data_o.out_x);
          check_field("out_y", exp_pt.out_y, out_data_o.out_y);
          check_field("out_z", exp_pt.out_z, out_data_o.out_z);
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!held_once && points_seen >= 100 && request_q.size() > 1) begin
        held_once <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (out_valid_o && out_ready) begin
        draw = no_gaps ? 0 : $urandom_range(0, 9);
        out_stall <= (draw > 0) ? draw - 1 : 0;
        out_ready <= (draw == 0);
      end else if (out_stall > 0) begin
        out_stall <= out_stall - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready) || (cfg_valid && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("Verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic write_reg(cfg_idx_e idx, int val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(val);
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ORDER: cfg_order = val & 4'hf;
      CFG_DIMS:  cfg_dims = val & 2'h3;
      CFG_PCNT:  cfg_points = val & 9'h1ff;
      default:   cfg_samples = val & 16'hffff;
    endcase
  endtask

  task automatic set_curve(int k, int d, int n, int s);
    write_reg(CFG_ORDER, k);
    write_reg(CFG_DIMS, d);
    write_reg(CFG_PCNT, n);
    write_reg(CFG_SCNT, s);
    settings_done++;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (request_q.size() != 0 || in_valid || curve_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic queue_load(int slot, logic [CRD_W-1:0] x, logic [CRD_W-1:0] y,
                            logic [CRD_W-1:0] z);
    in_item_t item;
    item.req_type = REQ_LOAD;
    item.point_index = slot[PIDX_IN_W-1:0];
    item.coord_x = x;
    item.coord_y = y;
    item.coord_z = z;
    item.sample_index = $urandom;
    loaded[slot] = 1'b1;
    request_q.push_back(item);
    requests_sent++;
  endtask

  task automatic queue_sample(int sidx);
    in_item_t item;
    for (int i = 0; i < eff_points(); i++) begin
      if (!loaded[i]) queue_load(i, $urandom, $urandom, $urandom);
    end
    item.req_type = REQ_SAMPLE;
    item.point_index = $urandom;
    item.coord_x = $urandom;
    item.coord_y = $urandom;
    item.coord_z = $urandom;
    item.sample_index = sidx[IDX_W-1:0];
    request_q.push_back(item);
    requests_sent++;
  endtask

  task automatic queue_random_sample();
    int s1;
    s1 = (cfg_samples > 1) ? cfg_samples - 1 : 0;
    case ($urandom_range(0, 9))
      0: queue_sample($urandom_range(0, 65535));
      1: queue_sample(s1);
      2: queue_sample(s1 + 1);
      default: queue_sample($urandom_range(0, s1));
    endcase
  endtask

  task automatic queue_random_load();
    int slot;
    logic [CRD_W-1:0] c[3];
    slot = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                       : $urandom_range(0, eff_points() - 1);
    for (int a = 0; a < 3; a++) begin
      case ($urandom_range(0, 7))
        0: c[a] = 32'h7fffffff;
        1: c[a] = 32'h80000000;
        2: c[a] = 32'hffffffff;
        3: c[a] = $urandom_range(0, 32'h000fffff);
        default: c[a] = $urandom;
      endcase
    end
    queue_load(slot, c[0], c[1], c[2]);
  endtask

  initial begin
    int k;
    int n;
    int s;
    rst_ni = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_cycles = 0;
    errors = 0;
    requests_sent = 0;
    points_seen = 0;
    settings_done = 0;
    no_gaps = 1'b0;
    cfg_order = 4;
    cfg_dims = 3;
    cfg_points = 4;
    cfg_samples = 10;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_load(0, 32'h7fffffff, 32'h80000000, 32'h00000000);
    queue_load(1, 32'h80000000, 32'h7fffffff, 32'hffffffff);
    queue_load(2, 32'h00010000, 32'hffff0000, 32'h7fffffff);
    queue_load(3, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    queue_load(255, 32'hffffffff, 32'h00000001, 32'h12345678);
    foreach (loaded[i]) loaded[i] = loaded[i];
    queue_sample(0);
    queue_sample(1);
    queue_sample(5);
    queue_sample(9);
    queue_sample(10);
    queue_sample(65535);
    wait_drained();

    for (int p = 0; requests_sent < 1050; p++) begin
      case (p)
        0: set_curve(0, 0, 0, 0);
        1: set_curve(15, 1, 2, 65535);
        2: set_curve(8, 2, 511, 1);
        3: set_curve(1, 3, 1, 2);
        4: set_curve(8, 3, 256, 65535);
        5: set_curve(2, 2, 300, 3);
        default: begin
          k = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 4) : $urandom_range(0, 15);
          n = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 12) : $urandom_range(0, 511);
          s = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 65535);
          set_curve(k, $urandom_range(0, 3), n, s);
        end
      endcase
      no_gaps = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < 40; i++) begin
        if ($urandom_range(0, 9) < 7) queue_random_sample();
        else queue_random_load();
      end
      wait_drained();
    end

    if (curve_q.size() != 0) begin
      $display("%0t: %0d curve points never arrived", $time, curve_q.size());
      errors++;
    end
    $display("Sent %0d load and sample requests over %0d register settings;", requests_sent,
             settings_done);
    $display("checked %0d curve points, including one long output back-pressure stretch.",
             points_seen);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== bspline_curve_sampler_top.f =====
rtl/core/bcs_pkg.sv
rtl/core/bcs_ram.sv
rtl/core/bcs_div.sv
rtl/core/bcs_core.sv
rtl/core/bspline_curve_sampler_top.sv
verif/bspline_curve_sampler_top_tb.sv
